// ===== rtl/ps2md_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2md_pkg;

    localparam int DEFAULT_COORD_WIDTH = 12;

    // configuration port
    localparam int CFG_DATA_WIDTH  = 13;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WHEEL_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_WIDTH-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_DATA_WIDTH-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    // bits of the first packet byte
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    // packet phases
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_DY    = 2'd2;
    localparam logic [1:0] PHASE_WHEEL = 2'd3;

    // event kinds
    localparam logic KIND_MOVE  = 1'b0;
    localparam logic KIND_CLICK = 1'b1;

    // button codes
    localparam logic [2:0] CODE_MOVE       = 3'd0;
    localparam logic [2:0] CODE_LEFT       = 3'd1;
    localparam logic [2:0] CODE_RIGHT      = 3'd2;
    localparam logic [2:0] CODE_WHEEL_UP   = 3'd4;
    localparam logic [2:0] CODE_WHEEL_DOWN = 3'd5;

    // events of one packet; mask bit order is emit order:
    // wheel, move, left, right
    typedef struct packed {
        logic [3:0] mask;
        logic       wheel_down;
        logic       left_pressed;
        logic       right_pressed;
    } evt_grp_t;

endpackage

`default_nettype wire

// ===== rtl/ps2_mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// PS/2 mouse byte stream to pointer position and button/wheel events.
// ----------------------------------------------------------------------------
// Each input byte is decoded in the cycle it is taken; the byte that closes a
// packet loads its events (wheel, move, left, right, in that order, zero to
// four of them) into a result register, which sends one event per output
// transfer and flags the final one with last. A byte that yields no event does
// not hold the input off. A packet that yields n events holds the input off
// until its last event transfers; the next byte may be taken in the same cycle
// as that last transfer. Recenter moves the pointer to half the screen size
// without emitting an event. Configuration writes apply from the next cycle and
// are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder #(
    parameter int COORD_WIDTH = ps2md_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [ps2md_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ps2md_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  action,
    input  wire logic [7:0]                            data_byte,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       event_kind,
    output logic [COORD_WIDTH-1:0]                     cursor_x,
    output logic [COORD_WIDTH-1:0]                     cursor_y,
    output logic [2:0]                                 button_code,
    output logic                                       pressed,
    output logic                                       last
);
    import ps2md_pkg::*;

    logic                   wheel_enabled;
    logic [COORD_WIDTH:0]   eff_width;
    logic [COORD_WIDTH:0]   eff_height;
    logic                   free;
    logic                   take;
    logic                   grp_load;
    evt_grp_t               grp;
    logic [COORD_WIDTH-1:0] grp_x, grp_y;

    assign in_stall = !free;
    assign take     = in_valid && free;

    ps2md_cfg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .wheel_enabled (wheel_enabled),
        .eff_width     (eff_width),
        .eff_height    (eff_height)
    );

    ps2md_decode #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .action        (action),
        .data_byte     (data_byte),
        .wheel_enabled (wheel_enabled),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .grp_load      (grp_load),
        .grp           (grp),
        .grp_x         (grp_x),
        .grp_y         (grp_y)
    );

    ps2md_emit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_load    (grp_load),
        .grp         (grp),
        .grp_x       (grp_x),
        .grp_y       (grp_y),
        .free        (free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .button_code (button_code),
        .pressed     (pressed),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== rtl/ps2md_cfg.sv =====
// ----------------------------------------------------------------------------
// ps2md_cfg
// Configuration registers and effective screen size limits.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_cfg #(
    parameter int COORD_WIDTH = ps2md_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ps2md_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ps2md_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output logic                                      wheel_enabled,
    output logic [COORD_WIDTH:0]                      eff_width,
    output logic [COORD_WIDTH:0]                      eff_height
);
    import ps2md_pkg::*;

    localparam logic [31:0] SIZE_LIM = 32'(1) << COORD_WIDTH;

    logic                      wheel_reg;
    logic [CFG_DATA_WIDTH-1:0] width_reg;
    logic [CFG_DATA_WIDTH-1:0] height_reg;
    logic [31:0]               width_ext;
    logic [31:0]               height_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg  <= 1'b0;
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WHEEL_ENABLED: wheel_reg  <= cfg_data[0];
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the full coordinate range
    always_comb
    begin
        width_ext  = 32'(width_reg);
        height_ext = 32'(height_reg);

        if (width_ext == 32'd0)
            eff_width = (COORD_WIDTH+1)'(1);
        else if (width_ext > SIZE_LIM)
            eff_width = SIZE_LIM[COORD_WIDTH:0];
        else
            eff_width = width_ext[COORD_WIDTH:0];

        if (height_ext == 32'd0)
            eff_height = (COORD_WIDTH+1)'(1);
        else if (height_ext > SIZE_LIM)
            eff_height = SIZE_LIM[COORD_WIDTH:0];
        else
            eff_height = height_ext[COORD_WIDTH:0];
    end

    assign wheel_enabled = wheel_reg;

endmodule

`default_nettype wire

// ===== rtl/ps2md_decode.sv =====
// ----------------------------------------------------------------------------
// ps2md_decode
// Packet assembly, pointer update and event selection for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_decode #(
    parameter int COORD_WIDTH = ps2md_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   take,
    input  wire logic                   action,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   wheel_enabled,
    input  wire logic [COORD_WIDTH:0]   eff_width,
    input  wire logic [COORD_WIDTH:0]   eff_height,
    output logic                        grp_load,
    output ps2md_pkg::evt_grp_t         grp,
    output logic [COORD_WIDTH-1:0]      grp_x,
    output logic [COORD_WIDTH-1:0]      grp_y
);
    import ps2md_pkg::*;

    localparam int SW = COORD_WIDTH + 2;

    logic [1:0]             phase_reg, phase_next;
    logic [7:0]             pkt0_reg, pkt1_reg, pkt2_reg;
    logic [COORD_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [2:0]             prev_btn_reg, prev_btn_next;

    logic                   byte_used;
    logic                   pkt_end;
    logic [7:0]             b2;
    logic [SW-1:0]          dx_ext, dy_ext;
    logic [SW-1:0]          sum_x, sum_y;
    logic [COORD_WIDTH-1:0] clamp_x, clamp_y;
    logic                   moved;

    always_comb
    begin
        byte_used = take && !action &&
                    !(phase_reg == PHASE_FIRST && !data_byte[SYNC_BIT]);
        pkt_end   = (phase_reg == PHASE_WHEEL) ||
                    (phase_reg == PHASE_DY && !wheel_enabled);

        // packet end needs phase 2 or 3: byte 0 and 1 are already stored
        b2 = (phase_reg == PHASE_DY) ? data_byte : pkt2_reg;

        dx_ext = {{(SW-8){pkt0_reg[XSIGN_BIT]}}, pkt1_reg};
        dy_ext = {{(SW-8){pkt0_reg[YSIGN_BIT]}}, b2};
        sum_x  = {2'b00, pos_x_reg} + dx_ext;
        sum_y  = {2'b00, pos_y_reg} - dy_ext;

        if (sum_x[SW-1])
            clamp_x = '0;
        else if (sum_x[COORD_WIDTH:0] >= eff_width)
            clamp_x = COORD_WIDTH'(eff_width - (COORD_WIDTH+1)'(1));
        else
            clamp_x = sum_x[COORD_WIDTH-1:0];

        if (sum_y[SW-1])
            clamp_y = '0;
        else if (sum_y[COORD_WIDTH:0] >= eff_height)
            clamp_y = COORD_WIDTH'(eff_height - (COORD_WIDTH+1)'(1));
        else
            clamp_y = sum_y[COORD_WIDTH-1:0];

        moved = (dx_ext != '0) || (dy_ext != '0);

        grp.mask[0]       = wheel_enabled && (phase_reg == PHASE_WHEEL) &&
                            (data_byte != 8'd0);
        grp.mask[1]       = moved;
        grp.mask[2]       = pkt0_reg[0] ^ prev_btn_reg[0];
        grp.mask[3]       = pkt0_reg[1] ^ prev_btn_reg[1];
        grp.wheel_down    = data_byte[7];
        grp.left_pressed  = pkt0_reg[0];
        grp.right_pressed = pkt0_reg[1];

        phase_next    = phase_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        prev_btn_next = prev_btn_reg;
        grp_load      = 1'b0;

        if (take && action)
        begin
            pos_x_next = eff_width[COORD_WIDTH:1];
            pos_y_next = eff_height[COORD_WIDTH:1];
        end
        else if (byte_used)
        begin
            if (pkt_end)
            begin
                phase_next    = PHASE_FIRST;
                pos_x_next    = clamp_x;
                pos_y_next    = clamp_y;
                prev_btn_next = pkt0_reg[2:0];
                grp_load      = (grp.mask != 4'd0);
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end

        grp_x = clamp_x;
        grp_y = clamp_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            prev_btn_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_used)
        begin
            unique case (phase_reg)
                2'd0:    pkt0_reg <= data_byte;
                2'd1:    pkt1_reg <= data_byte;
                2'd2:    pkt2_reg <= data_byte;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2md_emit.sv =====
// ----------------------------------------------------------------------------
// ps2md_emit
// Result register: holds one packet's events and sends them one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_emit #(
    parameter int COORD_WIDTH = ps2md_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   grp_load,
    input  wire ps2md_pkg::evt_grp_t    grp,
    input  wire logic [COORD_WIDTH-1:0] grp_x,
    input  wire logic [COORD_WIDTH-1:0] grp_y,
    output logic                        free,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        event_kind,
    output logic [COORD_WIDTH-1:0]      cursor_x,
    output logic [COORD_WIDTH-1:0]      cursor_y,
    output logic [2:0]                  button_code,
    output logic                        pressed,
    output logic                        last
);
    import ps2md_pkg::*;

    logic                   valid_reg;
    evt_grp_t               grp_reg;
    logic [COORD_WIDTH-1:0] x_reg, y_reg;
    logic [3:0]             rest;
    logic                   xfer;

    always_comb
    begin
        // drop the lowest pending event
        rest = grp_reg.mask & (grp_reg.mask - 4'd1);
        last = (rest == 4'd0);
        xfer = valid_reg && !out_stall;
        free = !valid_reg || (xfer && last);

        priority if (grp_reg.mask[0])
        begin
            event_kind  = KIND_CLICK;
            button_code = grp_reg.wheel_down ? CODE_WHEEL_DOWN : CODE_WHEEL_UP;
            pressed     = 1'b1;
        end
        else if (grp_reg.mask[1])
        begin
            event_kind  = KIND_MOVE;
            button_code = CODE_MOVE;
            pressed     = 1'b0;
        end
        else if (grp_reg.mask[2])
        begin
            event_kind  = KIND_CLICK;
            button_code = CODE_LEFT;
            pressed     = grp_reg.left_pressed;
        end
        else
        begin
            event_kind  = KIND_CLICK;
            button_code = CODE_RIGHT;
            pressed     = grp_reg.right_pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= grp_load;
    end

    always_ff @(posedge clk)
    begin
        if (free && grp_load)
        begin
            grp_reg <= grp;
            x_reg   <= grp_x;
            y_reg   <= grp_y;
        end
        else if (xfer)
        begin
            grp_reg.mask <= rest;
        end
    end

    assign out_valid = valid_reg;
    assign cursor_x  = x_reg;
    assign cursor_y  = y_reg;

endmodule

`default_nettype wire

// ===== tb/ps2_mouse_packet_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_tb
// Self-checking bench for the PS/2 mouse packet decoder. Mouse bytes and
// recenter requests go in through a queue-fed driver with random gaps. Events
// come out under random stall. A bit-accurate decoder model tracks the packet
// phase, pointer position and button state, and predicts every event. The
// monitor compares each one field by field. A directed run covers sync drops,
// screen-size extremes, stale positions, wheel packets and a wheel switch
// mid-packet. Random packets and noise follow under changing screen and wheel
// settings.
// ----------------------------------------------------------------------------

module ps2_mouse_packet_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2md_pkg::*;

    localparam int COORD_W = DEFAULT_COORD_WIDTH;

    typedef struct {
        logic       act;
        logic [7:0] data;
    } mouse_input_t;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [2:0]         code;
        logic               pressed;
        logic               last;
    } pointer_event_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       action = 1'b0;
    logic [7:0]                 data_byte = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       event_kind;
    logic [COORD_W-1:0]         cursor_x;
    logic [COORD_W-1:0]         cursor_y;
    logic [2:0]                 button_code;
    logic                       pressed;
    logic                       last;

    mouse_input_t   byte_queue[$];
    pointer_event_t pending_events[$];

    // decoder model state and its copy of the registers
    logic        wheel_on = 1'b0;
    logic [12:0] scr_w = SCREEN_WIDTH_RESET;
    logic [12:0] scr_h = SCREEN_HEIGHT_RESET;
    int          phase = 0;
    logic [7:0]  pkt[3];
    int          pos_x = 0;
    int          pos_y = 0;
    logic [2:0]  prev_btn = 3'b000;

    logic byte_taken = 1'b0;
    logic event_taken = 1'b0;
    logic in_calm = 1'b0;
    logic out_calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   mismatch_count = 0;

    ps2_mouse_packet_decoder #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .cursor_x(cursor_x),
        .cursor_y(cursor_y),
        .button_code(button_code),
        .pressed(pressed),
        .last(last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic int screen_span(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > (1 << COORD_W))
            return 1 << COORD_W;
        return int'(v);
    endfunction

    function automatic int clip(input int v, input int span);
        if (v < 0)
            return 0;
        if (v >= span)
            return span - 1;
        return v;
    endfunction

    function automatic pointer_event_t make_event(input logic kind, input logic [2:0] code,
                                                  input logic prs);
        pointer_event_t ev;
        ev.kind = kind;
        ev.x = pos_x[COORD_W-1:0];
        ev.y = pos_y[COORD_W-1:0];
        ev.code = code;
        ev.pressed = prs;
        ev.last = 1'b0;
        return ev;
    endfunction

    function automatic void decode_mouse_byte(input logic act, input logic [7:0] b);
        int w;
        int h;
        int dx;
        int dy;
        int dz;
        int plen;
        logic [2:0] btn;
        pointer_event_t batch[$];
        w = screen_span(scr_w);
        h = screen_span(scr_h);
        if (act)
        begin
            pos_x = w / 2;
            pos_y = h / 2;
            return;
        end
        // out of sync: only a byte with the sync bit can open a packet
        if (phase == 0 && !b[SYNC_BIT])
            return;
        dz = 0;
        if (phase < 3)
            pkt[phase] = b;
        else
            dz = b[7] ? int'(b) - 256 : int'(b);
        phase++;
        plen = wheel_on ? 4 : 3;
        if (phase < plen)
            return;
        phase = 0;
        dx = pkt[0][XSIGN_BIT] ? int'(pkt[1]) - 256 : int'(pkt[1]);
        dy = pkt[0][YSIGN_BIT] ? int'(pkt[2]) - 256 : int'(pkt[2]);
        pos_x = clip(pos_x + dx, w);
        pos_y = clip(pos_y - dy, h);
        if (wheel_on && dz != 0)
            batch.push_back(make_event(KIND_CLICK, dz > 0 ? CODE_WHEEL_UP : CODE_WHEEL_DOWN,
                                       1'b1));
        if (dx != 0 || dy != 0)
            batch.push_back(make_event(KIND_MOVE, CODE_MOVE, 1'b0));
        btn = pkt[0][2:0];
        if (btn[0] != prev_btn[0])
            batch.push_back(make_event(KIND_CLICK, CODE_LEFT, btn[0]));
        if (btn[1] != prev_btn[1])
            batch.push_back(make_event(KIND_CLICK, CODE_RIGHT, btn[1]));
        prev_btn = btn;
        if (batch.size() > 0)
            batch[$].last = 1'b1;
        foreach (batch[i])
            pending_events.push_back(batch[i]);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        mouse_input_t nxt;
        if (rst_n && !(in_valid && !byte_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (byte_queue.size() > 0)
            begin
                nxt = byte_queue.pop_front();
                in_valid <= 1'b1;
                action <= nxt.act;
                data_byte <= nxt.data;
                gap_left <= in_calm ? 0 : $urandom_range(0, 12);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall: a fresh hold-off after every event transfer
    always @(negedge clk)
    begin
        int n;
        n = stall_left;
        if (event_taken)
            n = out_calm ? 0 : $urandom_range(0, 12);
        else if (n > 0)
            n = n - 1;
        stall_left = n;
        out_stall <= rst_n && n != 0;
    end

    // ------------------------------------------------------------------
    // monitor: predict on input transfer, compare on output transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pointer_event_t want;
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
            event_taken <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_mouse_byte(action, data_byte);
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected event code %0d at (%0d,%0d)",
                                              button_code, cursor_x, cursor_y));
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind got %0d want %0d",
                                                  event_kind, want.kind));
                    if (cursor_x !== want.x)
                        report_mismatch($sformatf("cursor_x got %0d want %0d",
                                                  cursor_x, want.x));
                    if (cursor_y !== want.y)
                        report_mismatch($sformatf("cursor_y got %0d want %0d",
                                                  cursor_y, want.y));
                    if (button_code !== want.code)
                        report_mismatch($sformatf("button_code got %0d want %0d",
                                                  button_code, want.code));
                    if (pressed !== want.pressed)
                        report_mismatch($sformatf("pressed got %0d want %0d (code %0d)",
                                                  pressed, want.pressed, want.code));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0d want %0d (code %0d)",
                                                  last, want.last, want.code));
                end
            end
            byte_taken <= in_valid && !in_stall;
            event_taken <= out_valid && !out_stall;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic act, input logic [7:0] b);
        mouse_input_t it;
        it.act = act;
        it.data = b;
        byte_queue.push_back(it);
    endfunction

    // quiet means: nothing queued, nothing offered, no event outstanding, held
    // at consecutive negedges so a byte that yields no event has cleared too
    task automatic settle();
        int quiet;
        quiet = 0;
        while (quiet < 4)
        begin
            @(negedge clk);
            if (byte_queue.size() == 0 && !in_valid && pending_events.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_WHEEL_ENABLED: wheel_on = val[0];
            REG_SCREEN_WIDTH:  scr_w = val;
            REG_SCREEN_HEIGHT: scr_h = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'($urandom_range(2, 16));
            3: return 13'd4096;
            4: return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    initial
    begin
        int bytes_sent;
        int seg_len;
        int r;
        logic [7:0] hdr;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, 1024 x 768, three-byte packets
        queue_byte(1'b0, 8'h00);                // no sync bit, dropped
        queue_byte(1'b1, 8'hFF);                // recenter, data ignored
        queue_byte(1'b0, 8'h39);                // left down, dx = dy = -256
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h0E);                // left up, right and middle down
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'h0E);                // nothing changed: no event
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h00);
        settle();

        // zero width acts as one, oversized height as the full range
        write_reg(REG_SCREEN_WIDTH, 13'd0);
        write_reg(REG_SCREEN_HEIGHT, 13'd8191);
        queue_byte(1'b1, 8'h00);
        settle();

        // height shrinks under a stale y; the next packet clamps it
        write_reg(REG_SCREEN_WIDTH, 13'd8191);
        write_reg(REG_SCREEN_HEIGHT, 13'd0);
        queue_byte(1'b0, 8'h08);
        queue_byte(1'b0, 8'h7F);
        queue_byte(1'b0, 8'h00);
        settle();

        // wheel packets: down, then zero wheel
        write_reg(REG_WHEEL_ENABLED, 13'd1);
        write_reg(REG_SCREEN_WIDTH, 13'd4096);
        write_reg(REG_SCREEN_HEIGHT, 13'd4096);
        queue_byte(1'b0, 8'h0B);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h80);
        queue_byte(1'b0, 8'h08);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h00);
        // three bytes of a wheel packet, then the wheel goes off
        queue_byte(1'b0, 8'h38);
        queue_byte(1'b0, 8'h01);
        queue_byte(1'b0, 8'hFF);
        settle();
        write_reg(REG_WHEEL_ENABLED, 13'd0);
        queue_byte(1'b0, 8'h7F);                // phase 3 byte still ends it
        settle();

        // random: segments of packets and noise under fresh settings
        bytes_sent = 0;
        while (bytes_sent < 500)
        begin
            write_reg(REG_WHEEL_ENABLED, 13'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SCREEN_WIDTH, pick_size());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SCREEN_HEIGHT, pick_size());
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(8, 30);
            repeat (seg_len)
            begin
                r = $urandom_range(0, 19);
                if (r < 16)
                begin
                    hdr = 8'($urandom);
                    hdr[SYNC_BIT] = 1'b1;
                    queue_byte(1'b0, hdr);
                    queue_byte(1'b0, $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
                    queue_byte(1'b0, $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
                    bytes_sent += 3;
                    if (wheel_on)
                    begin
                        queue_byte(1'b0, $urandom_range(0, 5) == 0 ? 8'h00 : 8'($urandom));
                        bytes_sent++;
                    end
                end
                else if (r < 18)
                begin
                    queue_byte(1'b1, 8'($urandom));
                    bytes_sent++;
                end
                else if (r == 18)
                begin
                    hdr = 8'($urandom);
                    queue_byte(1'b0, hdr);
                    if (hdr[SYNC_BIT])
                        bytes_sent++;
                end
                else
                begin
                    // broken packet: header and one delta only
                    hdr = 8'($urandom);
                    hdr[SYNC_BIT] = 1'b1;
                    queue_byte(1'b0, hdr);
                    queue_byte(1'b0, 8'($urandom));
                    bytes_sent += 2;
                end
            end
            settle();
        end

        in_calm = 1'b0;
        out_calm = 1'b0;
        settle();
        if (mismatch_count == 0)
            $display("ps2_mouse_packet_decoder_tb: clean");
        else
            $display("ps2_mouse_packet_decoder_tb: errors");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("ps2_mouse_packet_decoder_tb: errors");
        $finish;
    end

endmodule

// ===== ps2_mouse_packet_decoder.f =====
rtl/ps2md_pkg.sv
rtl/ps2md_cfg.sv
rtl/ps2md_decode.sv
rtl/ps2md_emit.sv
rtl/ps2_mouse_packet_decoder.sv
tb/ps2_mouse_packet_decoder_tb.sv
